// ----- design/assert_macros.svh -----
// Assertion macros shared by the link framer RTL.
// No dependencies; taken in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, muted while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/mlmf_pkg.sv -----
// Types and constants for the multiplayer link master framer.
// No dependencies; imported by multiplayer_link_master_framer_top.
package mlmf_pkg;

    localparam logic [15:0] HANDSHAKE_MASTER = 16'h8FFF;
    localparam logic [15:0] HANDSHAKE_SLAVE  = 16'hB9A0;
    localparam logic [15:0] REPLY_MASK       = 16'hFFFC;

    typedef enum logic [1:0] {
        REQ_XFER    = 2'd0,
        REQ_STAGE   = 2'd1,
        REQ_RESTART = 2'd2,
        REQ_UNUSED  = 2'd3
    } t_req;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] slave_word;
        logic [2:0]  word_index;
        logic [15:0] word_value;
    } t_in;

    typedef struct packed {
        logic [15:0] master_word;
        logic        rx_valid;
        logic [2:0]  rx_index;
        logic [15:0] rx_word;
        logic        packet_done;
        logic        packet_nonzero;
        logic        link_up;
    } t_out;

endpackage

// ----- design/multiplayer_link_master_framer_top.sv -----
// Multiplayer link master framer: handshake, packet framing and checksum.
// Depends on mlmf_pkg and assert_macros.svh.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) carries one request
//   per beat: a completed transfer with the slave's word, a command word to
//   stage, or a link restart. Output channel (o_out_valid / i_out_ready /
//   o_out_data) returns exactly one result beat per request, in order: the
//   word to send on the next transfer, any received command word with its
//   slot, the end-of-packet flags and the link state.
//   Results are registered: a request's result shows in the cycle after it
//   is accepted. Throughput is one request per cycle while results are taken;
//   the framer state and the single output register update in the same cycle.
//   When the receiver stalls, the result holds in the output register and
//   o_in_ready drops until the result is taken; a result taken in the same
//   cycle frees the register for the next request.
//   Reset (i_rst_n low at a clock edge) returns the link to handshake mode,
//   clears the staged and active command words, the checksum and the output
//   valid. A restart request does the same to the framer state.
`include "assert_macros.svh"

module multiplayer_link_master_framer_top
    import mlmf_pkg::*;
#(
    parameter int COMMAND_WORDS = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    localparam int SLOT_W = $clog2(COMMAND_WORDS + 1);
    localparam int IDX_W  = (SLOT_W > 3) ? SLOT_W : 3;

    logic              r_link_mode, n_link_mode;
    logic [1:0]        r_reply_count, n_reply_count;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [15:0]       r_running_sum, n_running_sum;
    logic [15:0]       r_sum_to_send, n_sum_to_send;
    logic [15:0]       r_active_tx [COMMAND_WORDS];
    logic [15:0]       n_active_tx [COMMAND_WORDS];
    logic [15:0]       r_staged_tx [COMMAND_WORDS];
    logic [15:0]       n_staged_tx [COMMAND_WORDS];
    logic              r_received_any, n_received_any;

    logic              r_out_valid;
    t_out              r_out;
    t_out              n_out;

    logic              accept;
    logic [15:0]       cur_mw;
    logic [SLOT_W-1:0] slot_m1;
    logic [IDX_W-1:0]  slot_m1_ext;
    logic              reply_match;
    t_req              req;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign req         = t_req'(i_in_data.req_type);
    assign slot_m1     = r_slot - SLOT_W'(1);
    assign slot_m1_ext = IDX_W'(slot_m1);
    assign reply_match = (i_in_data.slave_word & REPLY_MASK) == HANDSHAKE_SLAVE;

    // word sent in the transfer that just completed
    always_comb begin
        cur_mw = '0;
        if (!r_link_mode) begin
            cur_mw = HANDSHAKE_MASTER;
        end else if (r_slot == '0) begin
            cur_mw = r_sum_to_send;
        end else begin
            for (int i = 0; i < COMMAND_WORDS; i++) begin
                if (r_slot == SLOT_W'(i + 1)) begin
                    cur_mw = r_active_tx[i];
                end
            end
        end
    end

    always_comb begin
        n_link_mode    = r_link_mode;
        n_reply_count  = r_reply_count;
        n_slot         = r_slot;
        n_running_sum  = r_running_sum;
        n_sum_to_send  = r_sum_to_send;
        n_active_tx    = r_active_tx;
        n_staged_tx    = r_staged_tx;
        n_received_any = r_received_any;
        n_out          = '0;

        unique case (req)
            REQ_XFER: begin
                if (!r_link_mode) begin
                    if (reply_match) begin
                        n_reply_count = (r_reply_count == 2'd3) ? r_reply_count
                                                                : r_reply_count + 2'd1;
                    end else begin
                        n_reply_count = '0;
                    end
                    if (n_reply_count >= 2'd2) begin
                        n_link_mode   = 1'b1;
                        n_slot        = '0;
                        n_running_sum = '0;
                        n_sum_to_send = '0;
                    end
                end else if (r_slot == '0) begin
                    // checksum beat done: latch the staged command words
                    n_active_tx    = r_staged_tx;
                    n_running_sum  = '0;
                    n_received_any = 1'b0;
                    n_slot         = SLOT_W'(1);
                end else begin
                    n_running_sum = r_running_sum + cur_mw + i_in_data.slave_word;
                    if (i_in_data.slave_word != '0) begin
                        n_received_any = 1'b1;
                    end
                    n_out.rx_valid = 1'b1;
                    n_out.rx_index = slot_m1_ext[2:0];
                    n_out.rx_word  = i_in_data.slave_word;
                    if (r_slot >= SLOT_W'(COMMAND_WORDS)) begin
                        n_sum_to_send        = n_running_sum;
                        n_slot               = '0;
                        n_out.packet_done    = 1'b1;
                        n_out.packet_nonzero = n_received_any;
                    end else begin
                        n_slot = r_slot + SLOT_W'(1);
                    end
                end
            end
            REQ_STAGE: begin
                for (int i = 0; i < COMMAND_WORDS; i++) begin
                    if (32'(i_in_data.word_index) == i) begin
                        n_staged_tx[i] = i_in_data.word_value;
                    end
                end
            end
            REQ_RESTART: begin
                n_link_mode    = 1'b0;
                n_reply_count  = '0;
                n_slot         = '0;
                n_running_sum  = '0;
                n_sum_to_send  = '0;
                n_received_any = 1'b0;
                for (int i = 0; i < COMMAND_WORDS; i++) begin
                    n_active_tx[i] = '0;
                    n_staged_tx[i] = '0;
                end
            end
            REQ_UNUSED: begin
            end
            default: begin
            end
        endcase

        // word for the next transfer, from the updated state
        n_out.link_up = n_link_mode;
        if (!n_link_mode) begin
            n_out.master_word = HANDSHAKE_MASTER;
        end else if (n_slot == '0) begin
            n_out.master_word = n_sum_to_send;
        end else begin
            for (int i = 0; i < COMMAND_WORDS; i++) begin
                if (n_slot == SLOT_W'(i + 1)) begin
                    n_out.master_word = n_active_tx[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_mode    <= 1'b0;
            r_reply_count  <= '0;
            r_slot         <= '0;
            r_running_sum  <= '0;
            r_sum_to_send  <= '0;
            r_received_any <= 1'b0;
            r_out_valid    <= 1'b0;
            for (int i = 0; i < COMMAND_WORDS; i++) begin
                r_active_tx[i] <= '0;
                r_staged_tx[i] <= '0;
            end
        end else begin
            if (accept) begin
                r_link_mode    <= n_link_mode;
                r_reply_count  <= n_reply_count;
                r_slot         <= n_slot;
                r_running_sum  <= n_running_sum;
                r_sum_to_send  <= n_sum_to_send;
                r_received_any <= n_received_any;
                r_active_tx    <= n_active_tx;
                r_staged_tx    <= n_staged_tx;
                r_out_valid    <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid    <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    `ASSERT_CLK(a_slot_range, i_clk, i_rst_n, r_slot <= SLOT_W'(COMMAND_WORDS), "slot out of range")
    `ASSERT_CLK(a_handshake_slot, i_clk, i_rst_n, !r_link_mode |-> r_slot == '0, "slot moved during handshake")
    `ASSERT_CLK(a_rx_needs_link, i_clk, i_rst_n, (r_out_valid && r_out.rx_valid) |-> r_out.link_up, "word reported with link down")
    `ASSERT_CLK(a_done_is_rx, i_clk, i_rst_n, (r_out_valid && r_out.packet_done) |-> (r_out.rx_valid && r_slot == '0), "packet end without last word")
    `ASSERT_CLK_ALWAYS(a_reset_empty, i_clk, $past(!i_rst_n) |-> !r_out_valid, "result valid right after reset")

endmodule
